[hw/rtl/hec_pkg.sv]
package hec_pkg;

  // Widths of the codeword, the data word and the length fields
  localparam int CodeW = 31;
  localparam int DataW = 26;
  localparam int LenW  = 5;

  localparam logic [LenW-1:0] DataLenMin   = LenW'(1);
  localparam logic [LenW-1:0] DataLenMax   = LenW'(DataW);
  localparam logic [LenW-1:0] DataLenReset = LenW'(8);

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_CHECK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ENCODED = 2'd0,
    ST_CORRECT = 2'd1,
    ST_SINGLE  = 2'd2,
    ST_MULTI   = 2'd3
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [DataW-1:0] data_bits;
    logic [CodeW-1:0] received_code;
  } in_word_t;

  typedef struct packed {
    logic [CodeW-1:0] code_word;
    logic [LenW-1:0]  code_length;
    logic [LenW-1:0]  error_position;
    status_e          status;
  } result_t;

  // Least r with m + r + 1 <= 2^r, for m in 1..26
  function automatic logic [2:0] parity_count(input logic [LenW-1:0] m);
    logic [2:0] r;
    if (m <= LenW'(1)) begin
      r = 3'd2;
    end else if (m <= LenW'(4)) begin
      r = 3'd3;
    end else if (m <= LenW'(11)) begin
      r = 3'd4;
    end else begin
      r = 3'd5;
    end
    return r;
  endfunction

  // Drop data bits into the non-power-of-two positions, ascending
  function automatic logic [CodeW-1:0] place_data(input logic [DataW-1:0] data);
    logic [CodeW-1:0] word;
    int               di;
    word = '0;
    di   = 0;
    for (int pos = 1; pos <= CodeW; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        if (di < DataW) begin
          word[5'(pos - 1)] = data[5'(di)];
        end
        di++;
      end
    end
    return word;
  endfunction

  // XOR of the positions of all set bits: bit k is parity over positions with bit k set
  function automatic logic [LenW-1:0] syndrome(input logic [CodeW-1:0] word);
    logic [LenW-1:0] s;
    s = '0;
    for (int pos = 1; pos <= CodeW; pos++) begin
      if (word[5'(pos - 1)]) begin
        s = s ^ LenW'(pos);
      end
    end
    return s;
  endfunction

endpackage

[hw/rtl/hec_in_reg.sv]
module hec_in_reg import hec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             op_i,
  input  logic [DataW-1:0] data_bits_i,
  input  logic [CodeW-1:0] received_code_i,
  input  logic             take_i,
  output logic             valid_o,
  output in_word_t         word_o
);

  logic     valid_q, valid_d;
  in_word_t word_q;
  logic     accept;

  // stalls only when holding a word the next stage cannot take
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q.op            <= op_e'(op_i);
      word_q.data_bits     <= data_bits_i;
      word_q.received_code <= received_code_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

[hw/rtl/hec_datapath.sv]
module hec_datapath import hec_pkg::*; (
  input  in_word_t         word_i,
  input  logic [LenW-1:0]  data_length_i,
  input  logic [CodeW-1:0] last_codeword_i,
  output result_t          result_o
);

  logic [LenW-1:0]  m;
  logic [2:0]       r;
  logic [LenW-1:0]  n;
  logic [CodeW-1:0] nmask;
  logic [DataW-1:0] dmask;
  logic [CodeW-1:0] placed;
  logic [LenW-1:0]  enc_par;
  logic [CodeW-1:0] enc_word;
  logic [CodeW-1:0] rx;
  logic [LenW-1:0]  chk_syn;

  // saturate the data length into 1..26
  always_comb begin
    if (data_length_i < DataLenMin) begin
      m = DataLenMin;
    end else if (data_length_i > DataLenMax) begin
      m = DataLenMax;
    end else begin
      m = data_length_i;
    end
  end

  assign r     = parity_count(m);
  assign n     = m + LenW'(r);
  assign nmask = CodeW'((32'd1 << n) - 32'd1);
  assign dmask = DataW'((32'd1 << m) - 32'd1);

  // parity slots are still zero here, so the syndrome is the needed parity;
  // parity bits past r always come out zero
  assign placed  = place_data(word_i.data_bits & dmask);
  assign enc_par = syndrome(placed);

  always_comb begin
    enc_word = placed;
    for (int k = 0; k < LenW; k++) begin
      enc_word[5'((1 << k) - 1)] = enc_par[k];
    end
  end

  assign rx      = word_i.received_code & nmask;
  assign chk_syn = syndrome(rx);

  always_comb begin
    result_o.code_length = n;
    unique case (word_i.op)
      OP_ENCODE: begin
        result_o.code_word      = enc_word;
        result_o.error_position = '0;
        result_o.status         = ST_ENCODED;
      end
      OP_CHECK: begin
        result_o.code_word      = '0;
        result_o.error_position = chk_syn;
        if (chk_syn != '0) begin
          result_o.status = ST_SINGLE;
        end else if (rx == (last_codeword_i & nmask)) begin
          result_o.status = ST_CORRECT;
        end else begin
          result_o.status = ST_MULTI;
        end
      end
      default: begin
        result_o.code_word      = '0;
        result_o.error_position = '0;
        result_o.status         = ST_ENCODED;
      end
    endcase
  end

endmodule

[hw/rtl/hamming_encode_and_check_core.sv]
// Even-parity Hamming coder/checker for 1..26 data bits (cfg_data_i, reset 8; 0 acts
// as 1 and 27..31 as 26). op_i = 0 encodes data_bits_i into a codeword of m + r bits
// (parity at power-of-two positions, bit i = position i+1) and remembers it; op_i = 1
// computes the syndrome of received_code_i and reports correct, a single error at
// error_position_o, or multiple errors when the syndrome is zero but the word differs
// from the last encoded codeword. Errors are reported, never corrected. Throughput is
// one word per clock while out_stall_i is low: a word is held in the input register
// while the parity/syndrome XOR trees run on it, and the result is then registered in
// the output register, which raises out_valid_o. A held out_stall_i backs up through
// both registers; in_stall_o rises once both hold a word. A check accepted right after
// an encode already compares against that encode's codeword. Write cfg only while idle.
module hamming_encode_and_check_core import hec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration: data length
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LenW-1:0]  cfg_data_i,
  // input words
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             op_i,
  input  logic [DataW-1:0] data_bits_i,
  input  logic [CodeW-1:0] received_code_i,
  // result words
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CodeW-1:0] code_word_o,
  output logic [LenW-1:0]  code_length_o,
  output logic [LenW-1:0]  error_position_o,
  output logic [1:0]       status_o
);

  logic [LenW-1:0]  data_length_q;
  logic [CodeW-1:0] last_codeword_q, last_codeword_d;
  logic             out_valid_q, out_valid_d;
  result_t          result_q, result_d;

  logic             s1_valid;
  in_word_t         s1_word;
  logic             out_free;
  logic             advance;

  // output register can take a new word when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = s1_valid && out_free;

  hec_in_reg u_in_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .data_bits_i     (data_bits_i),
    .received_code_i (received_code_i),
    .take_i          (out_free),
    .valid_o         (s1_valid),
    .word_o          (s1_word)
  );

  hec_datapath u_datapath (
    .word_i          (s1_word),
    .data_length_i   (data_length_q),
    .last_codeword_i (last_codeword_q),
    .result_o        (result_d)
  );

  // config register: always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_length_q <= DataLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      data_length_q <= cfg_data_i;
    end
  end

  // remembered codeword updates when the encode word leaves the input stage,
  // so the following word already sees it
  always_comb begin
    last_codeword_d = last_codeword_q;
    if (advance && (s1_word.op == OP_ENCODE)) begin
      last_codeword_d = result_d.code_word;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_codeword_q <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      last_codeword_q <= last_codeword_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign code_word_o      = result_q.code_word;
  assign code_length_o    = result_q.code_length;
  assign error_position_o = result_q.error_position;
  assign status_o         = result_q.status;

  // encode leaving the input stage shows up as both result and remembered codeword
  a_last_matches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (s1_word.op == OP_ENCODE)) |=> (last_codeword_q == code_word_o))
    else $error("remembered codeword differs from encoded result");

  // a nonzero syndrome is always flagged as a single error and vice versa
  a_single_iff_syndrome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == ST_SINGLE) == (error_position_o != '0)))
    else $error("status and error position disagree");

  // encode results carry no error position, check results carry no codeword
  a_mode_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == ST_ENCODED) ? (error_position_o == '0)
                                              : (code_word_o == '0)))
    else $error("unused result field not zero");

  // input side stalls only while the output stage is full and held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  // remembered codeword only moves on an encode
  a_last_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && (s1_word.op == OP_ENCODE)) |=> $stable(last_codeword_q))
    else $error("remembered codeword changed without an encode");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

// Testbench for hamming_encode_and_check_core.
// A directed table runs first at the reset data length. Then a series of phases follows,
// each with its own data length, and each phase sends encode words followed by checks
// of the stored codeword with zero to three flipped positions or with random words.
module tb;
  import hec_pkg::*;

  localparam int WdLimit    = 5000;  // cycles with no handshake before giving up
  localparam int HoldLen    = 300;   // long receiver hold-off, fills the pipeline
  localparam int PhaseItems = 68;    // random words per data-length phase
  localparam int NumPhases  = 13;
  localparam int MaxReports = 10;

  // one row of the directed table; res is used only when typed is set
  typedef struct {
    op_e              op;
    logic [DataW-1:0] data;
    logic [CodeW-1:0] rx;
    bit               typed;
    result_t          res;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LenW-1:0]  cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic             op;
  logic [DataW-1:0] data_bits;
  logic [CodeW-1:0] received_code;
  logic             out_valid;
  logic             out_stall;
  logic [CodeW-1:0] code_word;
  logic [LenW-1:0]  code_length;
  logic [LenW-1:0]  error_position;
  logic [1:0]       status;

  // predictor state, tracked at the handshakes
  logic [LenW-1:0]  model_len;
  logic [CodeW-1:0] model_last;
  result_t          pending[$];   // expected result words, oldest first

  // typed expectation of the word currently offered
  bit               row_typed;
  result_t          row_res;

  stim_row_t        stim_rows[$];
  logic [LenW-1:0]  len_plan[NumPhases];

  bit               idle_en;
  int               hold_left;
  int               stall_left;
  int               idle_cycles;
  int               errors;
  int               n_enc;
  int               n_chk;
  int               n_res;

  hamming_encode_and_check_core uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .op_i             (op),
    .data_bits_i      (data_bits),
    .received_code_i  (received_code),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .code_word_o      (code_word),
    .code_length_o    (code_length),
    .error_position_o (error_position),
    .status_o         (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // register value to data bits m: saturate into 1..26
  function automatic int data_bits_eff(input logic [LenW-1:0] len_reg);
    int m;
    m = int'(len_reg);
    if (m < 1) begin
      m = 1;
    end
    if (m > DataW) begin
      m = DataW;
    end
    return m;
  endfunction

  // total codeword length m + r, r the least count with m + r + 1 <= 2^r
  function automatic int code_len(input logic [LenW-1:0] len_reg);
    int m;
    int r;
    m = data_bits_eff(len_reg);
    r = 0;
    while (m + r + 1 > (1 << r)) begin
      r++;
    end
    return m + r;
  endfunction

  function automatic logic [CodeW-1:0] low_ones(input int n);
    logic [CodeW-1:0] msk;
    msk = '0;
    for (int p = 0; p < n; p++) begin
      msk[p] = 1'b1;
    end
    return msk;
  endfunction

  // XOR of the 1-based indexes of all set positions up to n
  function automatic logic [LenW-1:0] pos_xor(input logic [CodeW-1:0] w, input int n);
    logic [LenW-1:0] s;
    s = '0;
    for (int p = 1; p <= n; p++) begin
      if (w[p-1]) begin
        s = s ^ LenW'(p);
      end
    end
    return s;
  endfunction

  function automatic result_t hamming_predict(input logic             op_v,
                                              input logic [DataW-1:0] d,
                                              input logic [CodeW-1:0] rx,
                                              input logic [LenW-1:0]  len_reg,
                                              input logic [CodeW-1:0] last_cw);
    result_t          res;
    int               m;
    int               n;
    int               di;
    logic [CodeW-1:0] w;
    logic [CodeW-1:0] nmask;
    logic [LenW-1:0]  s;
    m     = data_bits_eff(len_reg);
    n     = code_len(len_reg);
    nmask = low_ones(n);
    res.code_word      = '0;
    res.code_length    = LenW'(n);
    res.error_position = '0;
    if (op_v == OP_ENCODE) begin
      // data into non-power-of-two positions; parity slots still zero
      w  = '0;
      di = 0;
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) begin
          w[p-1] = d[di];
          di++;
        end
      end
      // with parity slots zero, each syndrome bit is the parity that slot needs
      s = pos_xor(w, n);
      for (int k = 0; k < n - m; k++) begin
        w[(1 << k) - 1] = s[k];
      end
      res.code_word = w;
      res.status    = ST_ENCODED;
    end else begin
      w = rx & nmask;
      s = pos_xor(w, n);
      res.error_position = s;
      if (s != '0) begin
        res.status = ST_SINGLE;
      end else if (w == (last_cw & nmask)) begin
        res.status = ST_CORRECT;
      end else begin
        res.status = ST_MULTI;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: tracks handshakes at the rising edge, predicts and checks
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t exp_r;
    result_t got_r;
    result_t pred_r;
    bit      moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        n_res++;
        got_r.code_word      = code_word;
        got_r.code_length    = code_length;
        got_r.error_position = error_position;
        got_r.status         = status_e'(status);
        if (pending.size() == 0) begin
          errors++;
          if (errors <= MaxReports) begin
            $display("unexpected result word: cw=%h len=%0d pos=%0d st=%0d",
                     got_r.code_word, got_r.code_length, got_r.error_position, status);
          end
        end else begin
          exp_r = pending.pop_front();
          if (got_r.code_word != exp_r.code_word || got_r.code_length != exp_r.code_length ||
              got_r.error_position != exp_r.error_position ||
              got_r.status != exp_r.status) begin
            errors++;
            if (errors <= MaxReports) begin
              $display("mismatch %0d: exp cw=%h len=%0d pos=%0d st=%0d", errors,
                       exp_r.code_word, exp_r.code_length, exp_r.error_position,
                       exp_r.status);
              $display("             got cw=%h len=%0d pos=%0d st=%0d",
                       got_r.code_word, got_r.code_length, got_r.error_position, status);
            end
          end
        end
      end
      // config only changes while idle, so its order against words does not matter
      if (cfg_valid && cfg_ready) begin
        moved     = 1'b1;
        model_len = cfg_data;
      end
      if (in_valid && !in_stall) begin
        moved  = 1'b1;
        pred_r = hamming_predict(op, data_bits, received_code, model_len, model_last);
        if (op == OP_ENCODE) begin
          model_last = pred_r.code_word;
          n_enc++;
        end else begin
          n_chk++;
        end
        pending.push_back(row_typed ? row_res : pred_r);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : watchdog
    while (idle_cycles < WdLimit) begin
      @(posedge clk);
    end
    $display("timeout: no handshake for %0d cycles, %0d results outstanding",
             WdLimit, pending.size());
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks; each starts and ends just after a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_word(input op_e op_v, input logic [DataW-1:0] d,
                           input logic [CodeW-1:0] rx, input bit typed, input result_t res);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      // gap: valid low, payload is noise
      in_valid      <= 1'b0;
      op            <= 1'($urandom);
      data_bits     <= DataW'($urandom);
      received_code <= CodeW'($urandom);
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    op            <= op_v;
    data_bits     <= d;
    received_code <= rx;
    row_typed      = typed;
    row_res        = res;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
  endtask

  // wait until every expected result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic write_len(input logic [LenW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input op_e op_v, input logic [DataW-1:0] d,
                         input logic [CodeW-1:0] rx, input bit typed,
                         input logic [CodeW-1:0] cw, input int len, input int pos,
                         input status_e st);
    stim_row_t row;
    row.op                 = op_v;
    row.data               = d;
    row.rx                 = rx;
    row.typed              = typed;
    row.res.code_word      = cw;
    row.res.code_length    = LenW'(len);
    row.res.error_position = LenW'(pos);
    row.res.status         = st;
    stim_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int               n;
    int               cnt;
    int               nchk;
    int               kind;
    int               a;
    int               b;
    int               c;
    bit               paused;
    logic [CodeW-1:0] rx;
    logic [CodeW-1:0] nm;

    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    op            = 1'b0;
    data_bits     = '0;
    received_code = '0;
    row_typed     = 1'b0;
    row_res       = '0;
    model_len     = DataLenReset;
    model_last    = '0;
    idle_en       = 1'b1;
    hold_left     = 0;
    idle_cycles   = 0;
    errors        = 0;
    n_enc         = 0;
    n_chk         = 0;
    n_res         = 0;
    paused        = 1'b0;

    // data lengths per phase: both ends, the saturating values, the r steps
    len_plan = '{LenW'(1), LenW'(26), LenW'(0), LenW'(31), LenW'(2), LenW'(4), LenW'(5),
                 LenW'(11), LenW'(12), LenW'(27), LenW'(3), LenW'(1), LenW'(8)};
    len_plan[11] = LenW'($urandom_range(1, 26));

    // Directed rows at the reset length m = 8, n = 12. All-ones data encodes to 0xF77.
    // check before any encode compares against the all-zero stored word
    add_row(OP_CHECK,  26'h0,       31'h0,        1, 31'h0,   12, 0,  ST_CORRECT);
    add_row(OP_ENCODE, 26'h0,       31'h0,        1, 31'h0,   12, 0,  ST_ENCODED);
    add_row(OP_ENCODE, 26'h3FFFFFF, 31'h7FFFFFFF, 1, 31'hF77, 12, 0,  ST_ENCODED);
    add_row(OP_CHECK,  26'h3FFFFFF, 31'hF77,      1, 31'h0,   12, 0,  ST_CORRECT);
    // all ones on 12 positions: syndrome is 1^2^..^12 = 12
    add_row(OP_CHECK,  26'h0,       31'h7FFFFFFF, 1, 31'h0,   12, 12, ST_SINGLE);
    add_row(OP_CHECK,  26'h0,       31'hF67,      1, 31'h0,   12, 5,  ST_SINGLE);
    // positions 1, 2, 3 flipped: zero syndrome, word differs
    add_row(OP_CHECK,  26'h0,       31'hF70,      1, 31'h0,   12, 0,  ST_MULTI);
    // positions 1 and 12 flipped: syndrome 13 lies beyond n
    add_row(OP_CHECK,  26'h0,       31'h776,      1, 31'h0,   12, 13, ST_SINGLE);
    // received bits above n are ignored
    add_row(OP_CHECK,  26'h0,       31'h7FFFFF77, 1, 31'h0,   12, 0,  ST_CORRECT);
    // data bits above m are ignored
    add_row(OP_ENCODE, 26'h3FFFF00, 31'h0,        1, 31'h0,   12, 0,  ST_ENCODED);
    add_row(OP_CHECK,  26'h0,       31'hF77,      1, 31'h0,   12, 0,  ST_MULTI);
    add_row(OP_CHECK,  26'h0,       31'h0,        1, 31'h0,   12, 0,  ST_CORRECT);
    add_row(OP_ENCODE, 26'h0000055, 31'h0,        0, 31'h0,   0,  0,  ST_ENCODED);
    add_row(OP_ENCODE, 26'h00000AA, 31'h2AAAAAAA, 0, 31'h0,   0,  0,  ST_ENCODED);
    add_row(OP_CHECK,  26'h1555555, 31'h123,      0, 31'h0,   0,  0,  ST_ENCODED);
    add_row(OP_ENCODE, 26'h2AAAAAA, 31'h0,        0, 31'h0,   0,  0,  ST_ENCODED);
    add_row(OP_CHECK,  26'h0,       31'h2AAAAAAA, 0, 31'h0,   0,  0,  ST_ENCODED);
    add_row(OP_CHECK,  26'h0,       31'h55555555, 0, 31'h0,   0,  0,  ST_ENCODED);
    add_row(OP_ENCODE, 26'h0000001, 31'h0,        0, 31'h0,   0,  0,  ST_ENCODED);
    add_row(OP_ENCODE, 26'h0000080, 31'h0,        0, 31'h0,   0,  0,  ST_ENCODED);
    add_row(OP_CHECK,  26'h0,       31'h0,        0, 31'h0,   0,  0,  ST_ENCODED);

    // reset held low from the start, released at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      send_word(stim_rows[i].op, stim_rows[i].data, stim_rows[i].rx, stim_rows[i].typed,
                stim_rows[i].res);
    end
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      // block is idle here, so the length register may change
      write_len(len_plan[ph]);
      n   = code_len(model_len);
      nm  = low_ones(n);
      cnt = 0;
      if (ph == 2) begin
        hold_left = HoldLen;     // receiver holds off while the sender keeps going
      end
      if (ph == NumPhases - 1) begin
        idle_en = 1'b0;          // last phase runs at full rate on both sides
      end
      while (cnt < PhaseItems) begin
        if (ph == 6 && !paused && cnt >= PhaseItems / 2) begin
          drain();               // sender pauses until the pipeline is empty
          paused = 1'b1;
        end
        nchk = 1;
        if ($urandom_range(0, 7) != 0) begin
          send_word(OP_ENCODE, DataW'($urandom), CodeW'($urandom), 1'b0, '0);
          cnt++;
          nchk = $urandom_range(1, 4);
        end
        // checks against the stored codeword, mostly close to it
        for (int k = 0; k < nchk; k++) begin
          kind = $urandom_range(0, 9);
          rx   = model_last;
          a    = $urandom_range(1, n);
          b    = $urandom_range(1, n);
          case (kind)
            0, 1, 2: begin
            end
            3, 4, 5: begin
              rx[a-1] = ~rx[a-1];
            end
            6, 7: begin
              rx[a-1] = ~rx[a-1];
              rx[b-1] = ~rx[b-1];
            end
            8: begin
              // three flips with index XOR 0, undetectable by syndrome, or else one flip
              c = a ^ b;
              rx[a-1] = ~rx[a-1];
              if (a != b && c <= n) begin
                rx[b-1] = ~rx[b-1];
                rx[c-1] = ~rx[c-1];
              end
            end
            default: begin
              rx = CodeW'($urandom);
            end
          endcase
          if ($urandom_range(0, 1) == 1) begin
            rx = (rx & nm) | (CodeW'($urandom) & ~nm);
          end
          send_word(OP_CHECK, DataW'($urandom), rx, 1'b0, '0);
          cnt++;
        end
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (pending.size() != 0) begin
      errors += pending.size();
      $display("%0d expected result words never arrived", pending.size());
    end

    $display("Run: %0d encode and %0d check words, %0d results, %0d length settings",
             n_enc, n_chk, n_res, NumPhases + 1);
    $display("Run: random idling on both sides, one long output hold-off, %0d errors",
             errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/hec_pkg.sv
hw/rtl/hec_in_reg.sv
hw/rtl/hec_datapath.sv
hw/rtl/hamming_encode_and_check_core.sv
tb/sv/tb.sv
